// File: sv/kfc_pkg.sv
// ----------------------------------------------------------------------------
// kfc_pkg: shared types and constants of the keypad calculator
// Key codes, operator, action and serial-unit codes, and the request struct
// passed from the controller to the serial arithmetic unit.
// ----------------------------------------------------------------------------
package kfc_pkg;

    localparam int KEY_W    = 8;
    localparam int ACTION_W = 3;
    localparam int RESULT_W = 32;
    localparam int DIGIT_W  = 4;

    localparam logic [KEY_W-1:0] KEY_0     = 8'h30;
    localparam logic [KEY_W-1:0] KEY_9     = 8'h39;
    localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
    localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_TIMES = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_SLASH = 8'h2F;
    localparam logic [KEY_W-1:0] KEY_EQUAL = 8'h3D;
    localparam logic [KEY_W-1:0] KEY_CLEAR = 8'h63;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } operator_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE,
        ACT_ECHO,
        ACT_SHOW,
        ACT_DIVZ,
        ACT_CLEAR
    } action_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MAC10
    } alu_op_t;

    typedef struct packed {
        alu_op_t              op;
        logic [DIGIT_W-1:0]   digit;
    } alu_req_t;

    function automatic operator_t op_of_key(input logic [KEY_W-1:0] key);
        operator_t op;
        case (key)
            KEY_PLUS:  op = OP_ADD;
            KEY_MINUS: op = OP_SUB;
            KEY_TIMES: op = OP_MUL;
            KEY_SLASH: op = OP_DIV;
            default:   op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic alu_op_t alu_op_of(input operator_t op);
        alu_op_t a;
        case (op)
            OP_ADD:  a = ALU_ADD;
            OP_SUB:  a = ALU_SUB;
            OP_MUL:  a = ALU_MUL;
            OP_DIV:  a = ALU_DIV;
            default: a = ALU_ADD;
        endcase
        return a;
    endfunction

endpackage

// File: sv/kfc_channels.sv
// ----------------------------------------------------------------------------
// kfc_channels: valid/ready channels of the keypad calculator
// One interface for incoming key codes, one for outgoing display results.
// ----------------------------------------------------------------------------
interface kfc_key_if;
    logic                        valid;
    logic                        ready;
    logic [kfc_pkg::KEY_W-1:0]   key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

interface kfc_result_if;
    logic                          valid;
    logic                          ready;
    logic [kfc_pkg::ACTION_W-1:0]  action;
    logic [kfc_pkg::KEY_W-1:0]     echo_char;
    logic [kfc_pkg::RESULT_W-1:0]  result_value;

    modport source (output valid, output action, output echo_char, output result_value,
                    input ready);
    modport sink   (input valid, input action, input echo_char, input result_value,
                    output ready);
endinterface

// File: sv/keypad_four_function_calculator.sv
// ----------------------------------------------------------------------------
// keypad_four_function_calculator: four-function keypad calculator
// Decodes one key per transaction, keeps the operands, the pending operator
// and the last result, and reports one display action per key.
// ----------------------------------------------------------------------------
//  channel   dir  transaction payload
//  keys      in   key_code
//  results   out  action, echo_char, result_value
//
//  A digit key, or '=' with an operator pending (but for a division by
//  zero), runs through the serial unit in S_CALC and then S_POST, which
//  loads its result into the output register; the next key is taken once
//  the state is back in S_IDLE. Other keys go from S_IDLE straight to
//  S_POST. One key is in work at a time.
//  Reset clears operands, operator, entry phase and last result to zero.
//  A result waits in the output register while results.ready is low; the
//  next key may still be taken meanwhile, and its result holds until free.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    kfc_key_if.sink               keys,
    kfc_result_if.source          results
);
    import kfc_pkg::*;

    localparam int SHOW_W = (VALUE_BITS < RESULT_W) ? VALUE_BITS : RESULT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_POST
    } state_t;

    function automatic logic [RESULT_W-1:0] fit_result(input logic [VALUE_BITS-1:0] v);
        logic [RESULT_W-1:0] r;
        r = '0;
        r[SHOW_W-1:0] = v[SHOW_W-1:0];
        return r;
    endfunction

    state_t                  state_reg,      state_next;
    logic [VALUE_BITS-1:0]   first_reg,      first_next;
    logic [VALUE_BITS-1:0]   second_reg,     second_next;
    logic [VALUE_BITS-1:0]   last_reg,       last_next;
    operator_t               pend_op_reg,    pend_op_next;
    logic                    phase_reg,      phase_next;
    logic                    calc_digit_reg, calc_digit_next;
    logic [KEY_W-1:0]        key_reg,        key_next;
    action_t                 pact_reg,       pact_next;
    logic [KEY_W-1:0]        pecho_reg,      pecho_next;
    logic [RESULT_W-1:0]     pvalue_reg,     pvalue_next;
    logic                    out_valid_reg,  out_valid_next;
    action_t                 out_act_reg,    out_act_next;
    logic [KEY_W-1:0]        out_echo_reg,   out_echo_next;
    logic [RESULT_W-1:0]     out_value_reg,  out_value_next;

    logic                    alu_start;
    alu_req_t                alu_req;
    logic [VALUE_BITS-1:0]   alu_a;
    logic [VALUE_BITS-1:0]   alu_b;
    logic                    alu_done;
    logic [VALUE_BITS-1:0]   alu_result;

    logic                    key_take;
    logic [KEY_W-1:0]        key;
    logic                    key_is_digit;
    operator_t               key_op;
    logic [KEY_W-1:0]        digit_full;

    kfc_serial_alu #(
        .WIDTH (VALUE_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .done   (alu_done),
        .result (alu_result)
    );

    assign keys.ready   = (state_reg == S_IDLE);
    assign key_take     = keys.valid && keys.ready;
    assign key          = keys.key_code;
    assign key_is_digit = (key >= KEY_0) && (key <= KEY_9);
    assign key_op       = op_of_key(key);
    assign digit_full   = key - KEY_0;

    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        last_next       = last_reg;
        pend_op_next    = pend_op_reg;
        phase_next      = phase_reg;
        calc_digit_next = calc_digit_reg;
        key_next        = key_reg;
        pact_next       = pact_reg;
        pecho_next      = pecho_reg;
        pvalue_next     = pvalue_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_act_next    = out_act_reg;
        out_echo_next   = out_echo_reg;
        out_value_next  = out_value_reg;

        alu_start     = 1'b0;
        alu_req.op    = ALU_MAC10;
        alu_req.digit = digit_full[DIGIT_W-1:0];
        alu_a         = phase_reg ? second_reg : first_reg;
        alu_b         = second_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (key_take)
                begin
                    key_next    = key;
                    pact_next   = ACT_NONE;
                    pecho_next  = '0;
                    pvalue_next = '0;
                    state_next  = S_POST;
                    if (key_is_digit)
                    begin
                        alu_start       = 1'b1;
                        calc_digit_next = 1'b1;
                        state_next      = S_CALC;
                    end
                    else if (key_op != OP_NONE)
                    begin
                        pend_op_next = key_op;
                        phase_next   = 1'b1;
                        pact_next    = ACT_ECHO;
                        pecho_next   = key;
                    end
                    else if (key == KEY_EQUAL)
                    begin
                        if (pend_op_reg == OP_NONE)
                        begin
                            pact_next   = ACT_SHOW;
                            pvalue_next = fit_result(last_reg);
                        end
                        else if ((pend_op_reg == OP_DIV) && (second_reg == '0))
                        begin
                            pact_next   = ACT_DIVZ;
                            pvalue_next = fit_result(last_reg);
                        end
                        else
                        begin
                            alu_start       = 1'b1;
                            alu_req.op      = alu_op_of(pend_op_reg);
                            alu_a           = first_reg;
                            calc_digit_next = 1'b0;
                            state_next      = S_CALC;
                        end
                    end
                    else if (key == KEY_CLEAR)
                    begin
                        first_next   = '0;
                        second_next  = '0;
                        last_next    = '0;
                        pend_op_next = OP_NONE;
                        phase_next   = 1'b0;
                        pact_next    = ACT_CLEAR;
                    end
                end
            end
            S_CALC:
            begin
                if (alu_done)
                begin
                    if (calc_digit_reg)
                    begin
                        if (phase_reg)
                        begin
                            second_next = alu_result;
                        end
                        else
                        begin
                            first_next = alu_result;
                        end
                        pact_next   = ACT_ECHO;
                        pecho_next  = key_reg;
                        pvalue_next = '0;
                    end
                    else
                    begin
                        last_next   = alu_result;
                        pact_next   = ACT_SHOW;
                        pecho_next  = '0;
                        pvalue_next = fit_result(alu_result);
                    end
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                // hold until the output register is free
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = pact_reg;
                    out_echo_next  = pecho_reg;
                    out_value_next = pvalue_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_reg      <= '0;
            second_reg     <= '0;
            last_reg       <= '0;
            pend_op_reg    <= OP_NONE;
            phase_reg      <= 1'b0;
            calc_digit_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            last_reg       <= last_next;
            pend_op_reg    <= pend_op_next;
            phase_reg      <= phase_next;
            calc_digit_reg <= calc_digit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        pact_reg      <= pact_next;
        pecho_reg     <= pecho_next;
        pvalue_reg    <= pvalue_next;
        out_act_reg   <= out_act_next;
        out_echo_reg  <= out_echo_next;
        out_value_reg <= out_value_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.action       = out_act_reg;
    assign results.echo_char    = out_echo_reg;
    assign results.result_value = out_value_reg;

endmodule

// File: sv/kfc_serial_alu.sv
// ----------------------------------------------------------------------------
// kfc_serial_alu: serial arithmetic unit
// Add, subtract and times-ten-plus-digit run bit-serial through shift
// registers; multiply and divide retire one multiplier or quotient bit per
// cycle. Every operation ends with a pulse on done.
// ----------------------------------------------------------------------------
module kfc_serial_alu #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  kfc_pkg::alu_req_t       req,
    input  logic [WIDTH-1:0]        a,
    input  logic [WIDTH-1:0]        b,
    output logic                    done,
    output logic [WIDTH-1:0]        result
);
    import kfc_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    alu_op_t             op_reg,    op_next;
    logic [WIDTH-1:0]    x_reg,     x_next;
    logic [WIDTH-1:0]    y_reg,     y_next;
    logic [WIDTH-1:0]    acc_reg,   acc_next;
    logic [DIGIT_W-1:0]  d_reg,     d_next;
    logic [1:0]          carry_reg, carry_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic                run_reg,   run_next;
    logic                done_reg,  done_next;

    logic [2:0]          bit_sum;
    logic [WIDTH-1:0]    prod_step;
    logic [WIDTH:0]      trial;
    logic [WIDTH:0]      diff;

    always_comb
    begin
        bit_sum   = {2'b00, x_reg[0]} + {2'b00, y_reg[0]} + {2'b00, d_reg[0]}
                  + {1'b0, carry_reg};
        prod_step = {acc_reg[WIDTH-2:0], 1'b0} + (y_reg[WIDTH-1] ? x_reg : '0);
        trial     = {acc_reg, x_reg[WIDTH-1]};
        diff      = trial - {1'b0, y_reg};
    end

    always_comb
    begin
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        d_next     = d_reg;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;

        if (start)
        begin
            op_next    = req.op;
            acc_next   = '0;
            d_next     = '0;
            carry_next = 2'b00;
            cnt_next   = CNT_W'(WIDTH - 1);
            run_next   = 1'b1;
            x_next     = a;
            y_next     = b;
            case (req.op)
                ALU_MAC10:
                begin
                    // x*10 + d as (x << 3) + (x << 1) + d
                    x_next = a << 3;
                    y_next = a << 1;
                    d_next = req.digit;
                end
                ALU_SUB:
                begin
                    y_next     = ~b;
                    carry_next = 2'b01;
                end
                default:
                begin
                end
            endcase
        end
        else if (run_reg)
        begin
            case (op_reg)
                ALU_MUL:
                begin
                    acc_next = prod_step;
                    y_next   = {y_reg[WIDTH-2:0], 1'b0};
                end
                ALU_DIV:
                begin
                    // restoring step; quotient bits shift into x from the bottom
                    if (!diff[WIDTH])
                    begin
                        acc_next = diff[WIDTH-1:0];
                        x_next   = {x_reg[WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = trial[WIDTH-1:0];
                        x_next   = {x_reg[WIDTH-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next   = {bit_sum[0], acc_reg[WIDTH-1:1]};
                    carry_next = bit_sum[2:1];
                    x_next     = {1'b0, x_reg[WIDTH-1:1]};
                    y_next     = {1'b0, y_reg[WIDTH-1:1]};
                    d_next     = {1'b0, d_reg[DIGIT_W-1:1]};
                end
            endcase
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= ALU_ADD;
            cnt_reg   <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            carry_reg <= 2'b00;
        end
        else
        begin
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        d_reg   <= d_next;
    end

    assign done   = done_reg;
    assign result = (op_reg == ALU_DIV) ? x_reg : acc_reg;

endmodule

// File: test/kfc_calc_checker.sv
// ----------------------------------------------------------------------------
// kfc_calc_checker: display checker for the keypad calculator
// Watches the key and result channels, keeps a model of the operands, the
// pending operator, the entry phase and the last result, and compares each
// result transaction against the oldest predicted display.
// ----------------------------------------------------------------------------
module kfc_calc_checker (
    input  logic    clk,
    input  logic    rst_n,
    kfc_key_if      keys,
    kfc_result_if   results,
    output int      errors,
    output int      outstanding
);
    import kfc_pkg::*;

    typedef struct packed {
        action_t               act;
        logic [KEY_W-1:0]      ch;
        logic [RESULT_W-1:0]   val;
    } display_t;

    display_t              shown_q [$];
    logic [RESULT_W-1:0]   operand_a;
    logic [RESULT_W-1:0]   operand_b;
    logic [RESULT_W-1:0]   last_value;
    operator_t             pend_op;
    logic                  second_phase;

    // Advance the calculator model by one key and queue the display it causes.
    task automatic press(input logic [KEY_W-1:0] key);
        display_t              d;
        logic [RESULT_W-1:0]   digit;
        d = '{ACT_NONE, '0, '0};
        if (key >= KEY_0 && key <= KEY_9) begin
            digit = RESULT_W'(key - KEY_0);
            if (second_phase)
                operand_b = operand_b * 10 + digit;
            else
                operand_a = operand_a * 10 + digit;
            d.act = ACT_ECHO;
            d.ch  = key;
        end
        else begin
            case (key)
                KEY_PLUS, KEY_MINUS, KEY_TIMES, KEY_SLASH:
                begin
                    pend_op = (key == KEY_PLUS)  ? OP_ADD :
                              (key == KEY_MINUS) ? OP_SUB :
                              (key == KEY_TIMES) ? OP_MUL : OP_DIV;
                    second_phase = 1'b1;
                    d.act = ACT_ECHO;
                    d.ch  = key;
                end
                KEY_EQUAL:
                begin
                    d.act = ACT_SHOW;
                    case (pend_op)
                        OP_ADD: last_value = operand_a + operand_b;
                        OP_SUB: last_value = operand_a - operand_b;
                        OP_MUL: last_value = operand_a * operand_b;
                        OP_DIV:
                        begin
                            // keep the old result on a zero divisor
                            if (operand_b == '0)
                                d.act = ACT_DIVZ;
                            else
                                last_value = operand_a / operand_b;
                        end
                        default: ;
                    endcase
                    d.val = last_value;
                end
                KEY_CLEAR:
                begin
                    operand_a    = '0;
                    operand_b    = '0;
                    last_value   = '0;
                    pend_op      = OP_NONE;
                    second_phase = 1'b0;
                    d.act        = ACT_CLEAR;
                end
                default: ;
            endcase
        end
        shown_q.push_back(d);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        display_t want;
        display_t got;
        if (!rst_n)
        begin
            operand_a    = '0;
            operand_b    = '0;
            last_value   = '0;
            pend_op      = OP_NONE;
            second_phase = 1'b0;
            shown_q.delete();
            errors      <= 0;
            outstanding  = 0;
        end
        else
        begin
            // check the result first: it always belongs to an older key
            if (results.valid && results.ready)
            begin
                got = '{action_t'(results.action), results.echo_char, results.result_value};
                if (shown_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected display: action %0d char %02h value %08h",
                                 got.act, got.ch, got.val);
                    errors <= errors + 1;
                end
                else
                begin
                    want = shown_q.pop_front();
                    if (got.act !== want.act || got.ch !== want.ch || got.val !== want.val)
                    begin
                        if (errors < 10)
                            $display({"display mismatch: expected action %0d char %02h ",
                                      "value %08h, got action %0d char %02h value %08h"},
                                     want.act, want.ch, want.val,
                                     got.act, got.ch, got.val);
                        errors <= errors + 1;
                    end
                end
            end
            if (keys.valid && keys.ready)
                press(keys.key_code);
            outstanding = shown_q.size();
        end
    end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the keypad four-function calculator
// Drives a short directed key sequence and then random calculations, mostly
// well-formed operand/operator/equals runs with some noise, under random
// idling on both channels and one long output stall. The checker predicts
// every display and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import kfc_pkg::*;

    localparam int ITEMS = 1050;
    localparam int LIMIT = 400000;
    localparam int DRAIN = 60;
    localparam logic [KEY_W-1:0] KEY_UPPER_C = 8'h43;

    logic   clk    = 1'b0;
    logic   rst_n  = 1'b0;
    logic   hold   = 1'b0;
    logic   steady = 1'b0;
    int     errors;
    int     outstanding;
    int     sent   = 0;
    int     cycles = 0;

    logic [KEY_W-1:0] op_keys [4];
    logic [KEY_W-1:0] opening [$];

    kfc_key_if      keys ();
    kfc_result_if   results ();

    keypad_four_function_calculator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .keys    (keys),
        .results (results)
    );

    kfc_calc_checker calc_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .keys        (keys),
        .results     (results),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("keypad_four_function_calculator test failed");
            $finish;
        end
    end

    // Display side: random stalls, none in the steady stretch, held low during the hold-off.
    always @(posedge clk)
    begin
        if (hold)
            results.ready <= 1'b0;
        else if (steady)
            results.ready <= 1'b1;
        else
            results.ready <= ($urandom_range(0, 99) >= 17);
    end

    // Hold off the display side long enough for the key channel to back up.
    initial
    begin
        wait (sent >= 250);
        @(posedge clk);
        hold <= 1'b1;
        repeat (400) @(posedge clk);
        hold <= 1'b0;
    end

    task automatic send_key(input logic [KEY_W-1:0] k);
        while (!steady && $urandom_range(0, 99) < 17)
        begin
            keys.valid <= 1'b0;
            @(posedge clk);
        end
        keys.valid    <= 1'b1;
        keys.key_code <= k;
        @(posedge clk);
        while (!keys.ready)
            @(posedge clk);
        if ((k >= KEY_0 && k <= KEY_9) ||
            k inside {KEY_PLUS, KEY_MINUS, KEY_TIMES, KEY_SLASH, KEY_EQUAL, KEY_CLEAR})
            sent++;
        steady <= (sent >= 400 && sent < 560);
    endtask

    // Mostly short operands; now and then long enough to wrap 32 bits.
    function automatic int digit_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 4);
        else
            return $urandom_range(8, 12);
    endfunction

    task automatic send_number(input int n);
        repeat (n) send_key(KEY_0 + 8'($urandom_range(0, 9)));
    endtask

    initial
    begin : stimulus
        int                 pick;
        logic [KEY_W-1:0]   op;
        logic               zero_div;

        keys.valid    = 1'b0;
        keys.key_code = '0;
        op_keys = '{KEY_PLUS, KEY_MINUS, KEY_TIMES, KEY_SLASH};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // equals with no operator, wrapped subtraction, operands kept after
        // equals, divide by zero after clear, operator replacement, ignored keys
        opening = '{KEY_EQUAL, KEY_0 + 8'd1, KEY_0 + 8'd2, KEY_MINUS,
                    KEY_0 + 8'd3, KEY_0 + 8'd4, KEY_0 + 8'd5, KEY_EQUAL,
                    KEY_0 + 8'd6, KEY_EQUAL, KEY_CLEAR, KEY_0 + 8'd7, KEY_SLASH,
                    KEY_EQUAL, KEY_PLUS, KEY_TIMES, KEY_9, KEY_0, KEY_EQUAL,
                    KEY_UPPER_C, 8'h00, 8'hFF, KEY_CLEAR};
        foreach (opening[i])
            send_key(opening[i]);

        while (sent < ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                op = op_keys[$urandom_range(0, 3)];
                zero_div = (op == KEY_SLASH) && ($urandom_range(0, 2) == 0);
                if (zero_div || $urandom_range(0, 1) == 0)
                    send_key(KEY_CLEAR);
                send_number(digit_count());
                send_key(op);
                if (zero_div)
                    send_key(KEY_0);
                else
                    send_number(digit_count());
                send_key(KEY_EQUAL);
                if ($urandom_range(0, 2) == 0)
                begin
                    send_number(digit_count());
                    send_key(KEY_EQUAL);
                end
            end
            else if (pick < 85)
            begin
                // chain onto the kept operands
                send_key(op_keys[$urandom_range(0, 3)]);
                send_number(digit_count());
                send_key(KEY_EQUAL);
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_key(8'($urandom_range(0, 255)));
            end
        end
        keys.valid <= 1'b0;

        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("keypad_four_function_calculator test passed");
        else
            $display("keypad_four_function_calculator test failed");
        $finish;
    end

endmodule
